// ===== rtl/core/min_max_linear_partition_macros.svh =====
// Assertion macros shared by the RTL of the partition block
`ifndef MIN_MAX_LINEAR_PARTITION_MACROS_SVH
`define MIN_MAX_LINEAR_PARTITION_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define MMLP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define MMLP_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/mmlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlp_pkg
// Shared types and constants of the linear partition block.
// ----------------------------------------------------------------------------
package mmlp_pkg;
  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int AMOUNT_BITS_DEF = 16;
  localparam int AMOUNT_W        = 16;
  localparam int LIMIT_W         = 11;
  localparam int CAP_W           = 26;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_PASS,
    ST_DRAIN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // control from the sequencer to each cell
  typedef struct packed {
    logic       shift;  // advance the chain by one place
    logic       load;   // capture a new amount at the head
  } cell_ctl_t;
endpackage

// ===== rtl/core/min_max_linear_partition.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_linear_partition
// Binary search for the least group-sum cap over a stored amount sequence.
//
// channel  ports                         handshake
// input    in_amount, in_is_last         start & !busy
// result   out_minimal_cap, out_overflow out_valid, one cycle
// config   cfg_we, cfg_wdata             cfg_we
//
// After a non-last request the block stays ready for the next one. After a last
// request busy stays high through the search, one full rotation of the
// cell chain per search step, at most ceil(log2(total-largest+1)) steps.
// Reset is synchronous active low and empties the sequence count.
// The result strobes for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "min_max_linear_partition_macros.svh"
module min_max_linear_partition #(
  parameter int MAX_ITEMS   = mmlp_pkg::MAX_ITEMS_DEF,
  parameter int AMOUNT_BITS = mmlp_pkg::AMOUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mmlp_pkg::AMOUNT_W-1:0] in_amount,
  input  logic                        in_is_last,
  output logic                        out_valid,
  output logic [mmlp_pkg::CAP_W-1:0]  out_minimal_cap,
  output logic                        out_overflow,
  input  logic                        cfg_we,
  input  logic [mmlp_pkg::LIMIT_W-1:0] cfg_wdata
);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int TW  = AMOUNT_BITS + CW;        // total width
  localparam int RW  = $clog2(MAX_ITEMS + 4);
  localparam int SW  = RW + 1;                  // rotation plus count
  localparam int GW  = CW + 1;                  // group count width

  mmlp_pkg::state_t state_r, state_nxt;
  logic [mmlp_pkg::LIMIT_W-1:0] limit_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [TW-1:0]  tot_r, tot_nxt;
  logic [AMOUNT_BITS-1:0] big_r, big_nxt;
  logic           ovf_r, ovf_nxt;
  logic [TW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [TW:0]    acc_r, acc_nxt;
  logic [GW-1:0]  grp_r, grp_nxt;
  logic [RW-1:0]  rot_r, rot_nxt;
  logic           vo_r, vo_nxt;
  logic [mmlp_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic           ovo_r, ovo_nxt;
  mmlp_pkg::cell_ctl_t ctl;
  logic [AMOUNT_BITS-1:0] amt, head_amt;
  logic           take, room;

  assign amt  = AMOUNT_BITS'(in_amount);
  assign take = start && !busy;
  assign room = (cnt_r != CW'(MAX_ITEMS));

  mmlp_chain #(.N(MAX_ITEMS), .W(AMOUNT_BITS)) u_chain (
    .clk(clk), .ctl(ctl), .new_amt(amt),
    .out_amt(head_amt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmlp_pkg::ST_LOAD;
      limit_r <= mmlp_pkg::LIMIT_W'(1);
      cnt_r   <= '0;
      tot_r   <= '0;
      big_r   <= '0;
      ovf_r   <= 1'b0;
      vo_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
      big_r   <= big_nxt;
      ovf_r   <= ovf_nxt;
      vo_r    <= vo_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    acc_r <= acc_nxt;
    grp_r <= grp_nxt;
    rot_r <= rot_nxt;
    cap_r <= cap_nxt;
    ovo_r <= ovo_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; tot_nxt = tot_r; big_nxt = big_r; ovf_nxt = ovf_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r;
    acc_nxt = acc_r; grp_nxt = grp_r; rot_nxt = rot_r;
    cap_nxt = cap_r; ovo_nxt = ovo_r; vo_nxt = 1'b0;
    ctl = '0;
    busy = 1'b1;
    unique case (state_r)
      mmlp_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (take) begin
          if (room) begin
            ctl.shift = 1'b1;
            ctl.load  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            tot_nxt = tot_r + TW'(amt);
            if (amt > big_r) big_nxt = amt;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) state_nxt = mmlp_pkg::ST_INIT;
        end
      end
      mmlp_pkg::ST_INIT: begin
        lo_nxt = TW'(big_r);
        hi_nxt = tot_r;
        state_nxt = mmlp_pkg::ST_DECIDE;
      end
      mmlp_pkg::ST_DECIDE: begin
        if (lo_r < hi_r) begin
          mid_nxt = lo_r + ((hi_r - lo_r) >> 1);
          acc_nxt = '0;
          grp_nxt = GW'(1);
          rot_nxt = '0;
          state_nxt = mmlp_pkg::ST_PASS;
        end else begin
          cap_nxt = mmlp_pkg::CAP_W'(lo_r);
          ovo_nxt = ovf_r;
          vo_nxt  = 1'b1;
          state_nxt = mmlp_pkg::ST_DONE;
        end
      end
      mmlp_pkg::ST_PASS: begin
        // the oldest entry sits MAX_ITEMS-count places before the tail;
        // MAX_ITEMS shifts bring every entry past the tail in arrival order
        // and leave the chain where it started
        ctl.shift = 1'b1;
        rot_nxt = rot_r + RW'(1);
        if (SW'(rot_r) + SW'(cnt_r) >= SW'(MAX_ITEMS)) begin
          if (acc_r + (TW+1)'(head_amt) > {1'b0, mid_r}) begin
            acc_nxt = (TW+1)'(head_amt);
            grp_nxt = grp_r + GW'(1);
          end else begin
            acc_nxt = acc_r + (TW+1)'(head_amt);
          end
        end
        if (rot_r == RW'(MAX_ITEMS - 1)) state_nxt = mmlp_pkg::ST_DRAIN;
      end
      mmlp_pkg::ST_DRAIN: begin
        if (32'(grp_r) <= 32'(limit_r)) hi_nxt = mid_r;
        else lo_nxt = mid_r + TW'(1);
        state_nxt = mmlp_pkg::ST_DECIDE;
      end
      mmlp_pkg::ST_DONE: begin
        // drop the sequence; stale cells lie beyond the count
        cnt_nxt = '0; tot_nxt = '0; big_nxt = '0; ovf_nxt = 1'b0;
        state_nxt = mmlp_pkg::ST_LOAD;
      end
      default: state_nxt = mmlp_pkg::ST_LOAD;
    endcase
  end

  assign out_valid       = vo_r;
  assign out_minimal_cap = cap_r;
  assign out_overflow    = ovo_r;

  `MMLP_ASSERT_IMP(a_busy_strobe, clk, rst_n, out_valid, busy)
  `MMLP_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  `MMLP_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_ITEMS))
endmodule

// ===== rtl/core/mmlp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlp_cell
// One place of the amount chain: holds an amount and hands it to its
// neighbor on every shift.
// ----------------------------------------------------------------------------
module mmlp_cell #(
  parameter int W = mmlp_pkg::AMOUNT_BITS_DEF
) (
  input  logic              clk,
  input  mmlp_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]      prev_amt,
  output logic [W-1:0]      amt
);
  logic [W-1:0] amt_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      amt_r <= prev_amt;
    end
  end

  assign amt = amt_r;
endmodule

// ===== rtl/core/mmlp_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlp_chain
// Row of cells forming a circular shift line; the tail feeds the greedy
// pass and wraps back to the head.
// ----------------------------------------------------------------------------
module mmlp_chain #(
  parameter int N = mmlp_pkg::MAX_ITEMS_DEF,
  parameter int W = mmlp_pkg::AMOUNT_BITS_DEF
) (
  input  logic                clk,
  input  mmlp_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]        new_amt,
  output logic [W-1:0]        out_amt
);
  logic [W-1:0] amt_w [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] pa;
    if (i == 0) begin : g_head
      // load enters at the head; otherwise the tail wraps around
      assign pa = ctl.load ? new_amt : amt_w[N-1];
    end else begin : g_body
      assign pa = amt_w[i-1];
    end
    mmlp_cell #(.W(W)) u_cell (
      .clk(clk), .ctl(ctl),
      .prev_amt(pa),
      .amt(amt_w[i])
    );
  end

  assign out_amt = amt_w[N-1];
endmodule
